// ----- design/bst_pkg.sv -----
`default_nettype none
package bst_pkg;

  localparam int unsigned LVL_W = 6;

  typedef enum logic [2:0] {
    MODE_VALUE,
    MODE_STRLEN,
    MODE_STRBODY,
    MODE_INT_START,
    MODE_INT_NEG,
    MODE_INT_DIGITS,
    MODE_DONE,
    MODE_ERROR
  } mode_e;

  typedef enum logic [2:0] {
    KIND_STR_HDR,
    KIND_STR_BYTE,
    KIND_INT,
    KIND_LIST_OPEN,
    KIND_DICT_OPEN,
    KIND_CLOSE,
    KIND_ERROR
  } kind_e;

  typedef enum logic [2:0] {
    ERR_BAD_BYTE,
    ERR_TRUNCATED,
    ERR_INT_OVF,
    ERR_DEPTH,
    ERR_LEN_OVF
  } err_e;

  localparam logic [7:0] CH_I     = 8'h69;
  localparam logic [7:0] CH_L     = 8'h6c;
  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_E     = 8'h65;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Largest magnitude divided by ten, and the remainders for each sign
  localparam logic [63:0] INT_QUOT    = 64'd922337203685477580;
  localparam logic [3:0]  INT_REM_POS = 4'd7;
  localparam logic [3:0]  INT_REM_NEG = 4'd8;

  typedef struct packed {
    logic is_dict;
    logic wants_key;
  } lvl_entry_t;

  typedef struct packed {
    kind_e              kind;
    logic signed [63:0] value;
    logic [31:0]        byte_offset;
    logic [LVL_W-1:0]   nest_level;
    logic               is_dict_key;
    logic               value_complete;
    logic               top_done;
  } tok_t;

endpackage
`default_nettype wire

// ----- design/bst_if.sv -----
`default_nettype none
interface bst_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       buffer_end;

  modport source (output valid, output data_byte, output buffer_end, input ready);
  modport sink (input valid, input data_byte, input buffer_end, output ready);
endinterface

interface bst_tok_if;
  logic               valid;
  logic               ready;
  logic [2:0]         token_kind;
  logic signed [63:0] token_value;
  logic [31:0]        byte_offset;
  logic [5:0]         nest_level;
  logic               is_dict_key;
  logic               value_complete;
  logic               top_done;

  modport source (output valid, output token_kind, output token_value, output byte_offset,
                  output nest_level, output is_dict_key, output value_complete,
                  output top_done, input ready);
  modport sink (input valid, input token_kind, input token_value, input byte_offset,
                input nest_level, input is_dict_key, input value_complete,
                input top_done, output ready);
endinterface
`default_nettype wire

// ----- design/bencode_stream_tokenizer.sv -----
// Output: a token is registered in the output buffer when the byte that makes it is accepted.
// Throughput: one byte per cycle while the output buffer has room; the nesting stack's top sits in
//   flops and the entry below it is prefetched from the stack memory each cycle, so closes run back to back.
// A two-entry output buffer holds tokens; byte_i stalls only when both entries are full.
// Reset: asynchronous, active low; parser idle at depth zero, max_depth = 32, no clearing pass.
`default_nettype none
module bencode_stream_tokenizer #(
  parameter int unsigned MAX_NEST = 32,
  parameter int unsigned LEN_BITS = 32
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        cfg_we_i,
  input  wire  [5:0] cfg_wdata_i,
  bst_byte_if.sink   byte_i,
  bst_tok_if.source  token_o
);
  import bst_pkg::*;

  localparam int unsigned AW = (MAX_NEST > 1) ? $clog2(MAX_NEST) : 1;
  localparam logic [63:0] LEN_MAX  = (64'd1 << LEN_BITS) - 64'd1;
  localparam logic [63:0] LEN_QUOT = LEN_MAX / 10;
  localparam logic [3:0]  LEN_REM  = 4'(LEN_MAX % 10);

  mode_e mode_q, mode_d;
  logic [LEN_BITS-1:0] rem_q, rem_d;
  logic [63:0] mag_q, mag_d;
  logic neg_q, neg_d;
  logic [LVL_W-1:0] lvl_q, lvl_d;
  logic top_dict_q, top_dict_d, top_key_q, top_key_d;
  logic [31:0] pos_q, pos_d;
  logic [5:0] max_depth_q;

  logic acc, room, emit, err_v, fin, mem_we;
  err_e err_code;
  tok_t tok;
  lvl_entry_t mem_wdata, mem_rdata;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [LVL_W-1:0] lvl_m1, lvl_d_m2;

  logic [7:0] b;
  logic digit, indict, key, at_limit;
  logic [3:0] dval;
  logic [63:0] mag10;
  logic [LEN_BITS-1:0] rem_dec;

  assign acc          = byte_i.valid && byte_i.ready;
  assign byte_i.ready = room;

  assign b      = byte_i.data_byte;
  assign digit  = (b >= CH_ZERO) && (b <= CH_NINE);
  assign dval   = digit ? 4'(b - CH_ZERO) : 4'd0;
  assign mag10  = {mag_q[60:0], 3'b000} + {mag_q[62:0], 1'b0} + 64'(dval);
  assign indict = (lvl_q != '0) && top_dict_q;
  assign key    = indict && top_key_q;
  assign at_limit = (lvl_q >= max_depth_q) || (32'(lvl_q) >= MAX_NEST);
  assign rem_dec  = (rem_q != '0) ? rem_q - 1'b1 : rem_q;
  assign lvl_m1   = lvl_q - 1'b1;

  always_comb begin
    mode_d     = mode_q;
    rem_d      = rem_q;
    mag_d      = mag_q;
    neg_d      = neg_q;
    lvl_d      = lvl_q;
    top_dict_d = top_dict_q;
    top_key_d  = top_key_q;
    pos_d      = pos_q;
    emit       = 1'b0;
    err_v      = 1'b0;
    err_code   = ERR_BAD_BYTE;
    fin        = 1'b0;
    mem_we     = 1'b0;
    mem_wdata  = '{is_dict: top_dict_q, wants_key: top_key_q};
    tok        = '{kind: KIND_ERROR, value: '0, byte_offset: pos_q, nest_level: lvl_q,
                   is_dict_key: 1'b0, value_complete: 1'b0, top_done: 1'b0};

    if (acc) begin
      case (mode_q)
        MODE_VALUE: begin
          if (b == CH_E) begin
            if ((lvl_q == '0) || (indict && !key)) begin
              err_v = 1'b1;
            end else begin
              emit               = 1'b1;
              tok.kind           = KIND_CLOSE;
              tok.value_complete = 1'b1;
              tok.top_done       = (lvl_q == LVL_W'(1));
              lvl_d              = lvl_m1;
              // pop: parent comes from the prefetched entry below the top
              if (lvl_m1 == '0) begin
                mode_d = MODE_DONE;
              end else begin
                mode_d     = MODE_VALUE;
                top_dict_d = mem_rdata.is_dict;
                top_key_d  = mem_rdata.is_dict ? !mem_rdata.wants_key : mem_rdata.wants_key;
              end
            end
          end else if (key && !digit) begin
            err_v = 1'b1;
          end else if (digit) begin
            mag_d  = 64'(dval);
            mode_d = MODE_STRLEN;
          end else if (b == CH_I) begin
            mag_d  = '0;
            neg_d  = 1'b0;
            mode_d = MODE_INT_START;
          end else if ((b == CH_L) || (b == CH_D)) begin
            if (at_limit) begin
              err_v    = 1'b1;
              err_code = ERR_DEPTH;
            end else begin
              // push: spill the current top into the stack memory
              mem_we         = (lvl_q != '0);
              top_dict_d     = (b == CH_D);
              top_key_d      = (b == CH_D);
              lvl_d          = lvl_q + 1'b1;
              emit           = 1'b1;
              tok.kind       = (b == CH_D) ? KIND_DICT_OPEN : KIND_LIST_OPEN;
              tok.nest_level = lvl_q + 1'b1;
            end
          end else begin
            err_v = 1'b1;
          end
        end
        MODE_STRLEN: begin
          if (digit) begin
            if (mag_q == '0) begin
              err_v = 1'b1;
            end else if ((mag_q > LEN_QUOT) || ((mag_q == LEN_QUOT) && (dval > LEN_REM))) begin
              err_v    = 1'b1;
              err_code = ERR_LEN_OVF;
            end else begin
              mag_d = mag10;
            end
          end else if (b == CH_COLON) begin
            emit               = 1'b1;
            tok.kind           = KIND_STR_HDR;
            tok.value          = mag_q;
            tok.is_dict_key    = key;
            tok.value_complete = (mag_q == '0);
            tok.top_done       = (mag_q == '0) && (lvl_q == '0);
            if (mag_q == '0) begin
              fin = 1'b1;
            end else begin
              rem_d  = mag_q[LEN_BITS-1:0];
              mode_d = MODE_STRBODY;
            end
          end else begin
            err_v = 1'b1;
          end
        end
        MODE_STRBODY: begin
          emit               = 1'b1;
          tok.kind           = KIND_STR_BYTE;
          tok.value          = 64'(b);
          tok.is_dict_key    = key;
          tok.value_complete = (rem_dec == '0);
          tok.top_done       = (rem_dec == '0) && (lvl_q == '0);
          rem_d              = rem_dec;
          fin                = (rem_dec == '0);
        end
        MODE_INT_START: begin
          if (b == CH_MINUS) begin
            neg_d  = 1'b1;
            mode_d = MODE_INT_NEG;
          end else if (digit) begin
            mag_d  = 64'(dval);
            mode_d = MODE_INT_DIGITS;
          end else begin
            err_v = 1'b1;
          end
        end
        MODE_INT_NEG: begin
          if (digit && (dval != 4'd0)) begin
            mag_d  = 64'(dval);
            mode_d = MODE_INT_DIGITS;
          end else begin
            err_v = 1'b1;
          end
        end
        MODE_INT_DIGITS: begin
          if (digit) begin
            if (mag_q == '0) begin
              err_v = 1'b1;
            end else if ((mag_q > INT_QUOT) || ((mag_q == INT_QUOT) &&
                         (dval > (neg_q ? INT_REM_NEG : INT_REM_POS)))) begin
              err_v    = 1'b1;
              err_code = ERR_INT_OVF;
            end else begin
              mag_d = mag10;
            end
          end else if (b == CH_E) begin
            emit               = 1'b1;
            tok.kind           = KIND_INT;
            tok.value          = neg_q ? (64'd0 - mag_q) : mag_q;
            tok.value_complete = 1'b1;
            tok.top_done       = (lvl_q == '0);
            fin                = 1'b1;
          end else begin
            err_v = 1'b1;
          end
        end
        default: begin
        end
      endcase

      // value finished at the current level: done at level zero, else flip the dict's key/value phase
      if (fin) begin
        if (lvl_q == '0) begin
          mode_d = MODE_DONE;
        end else begin
          mode_d = MODE_VALUE;
          if (top_dict_q) begin
            top_key_d = !top_key_q;
          end
        end
      end

      if (err_v) begin
        emit = 1'b1;
        tok  = '{kind: KIND_ERROR, value: 64'(err_code), byte_offset: pos_q, nest_level: lvl_q,
                 is_dict_key: 1'b0, value_complete: 1'b0, top_done: 1'b0};
        mode_d = MODE_ERROR;
      end

      if (byte_i.buffer_end) begin
        if ((mode_d != MODE_DONE) && (mode_d != MODE_ERROR)) begin
          emit = 1'b1;
          tok  = '{kind: KIND_ERROR, value: 64'(ERR_TRUNCATED), byte_offset: pos_q,
                   nest_level: lvl_d, is_dict_key: 1'b0, value_complete: 1'b0,
                   top_done: 1'b0};
        end
        mode_d = MODE_VALUE;
        rem_d  = '0;
        mag_d  = '0;
        neg_d  = 1'b0;
        lvl_d  = '0;
        pos_d  = '0;
      end else begin
        pos_d = pos_q + 32'd1;
      end
    end
  end

  // prefetch the entry just below the next top of stack
  assign lvl_d_m2  = lvl_d - LVL_W'(2);
  assign mem_raddr = AW'(lvl_d_m2);
  assign mem_waddr = AW'(lvl_m1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_VALUE;
      rem_q       <= '0;
      mag_q       <= '0;
      neg_q       <= 1'b0;
      lvl_q       <= '0;
      pos_q       <= '0;
      max_depth_q <= 6'd32;
    end else begin
      mode_q <= mode_d;
      rem_q  <= rem_d;
      mag_q  <= mag_d;
      neg_q  <= neg_d;
      lvl_q  <= lvl_d;
      pos_q  <= pos_d;
      if (cfg_we_i) begin
        max_depth_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    top_dict_q <= top_dict_d;
    top_key_q  <= top_key_d;
  end

  bst_level_mem #(
    .DEPTH (MAX_NEST),
    .AW    (AW)
  ) u_level_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  bst_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (emit),
    .tok_i   (tok),
    .room_o  (room),
    .token_o (token_o)
  );

  a_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(lvl_q) <= MAX_NEST)
    else $error("nesting level beyond stack depth");

  a_done_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_DONE) |-> (lvl_q == '0))
    else $error("top value done with open containers");

  a_body_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_STRBODY) |-> (rem_q != '0))
    else $error("string body with nothing left");

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && byte_i.buffer_end) |=> ((pos_q == '0) && (lvl_q == '0) && (mode_q == MODE_VALUE)))
    else $error("last byte did not return parser to idle");

endmodule
`default_nettype wire

// ----- design/bst_level_mem.sv -----
`default_nettype none
module bst_level_mem #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = 5
) (
  input  wire                     clk_i,
  input  wire                     we_i,
  input  wire  [AW-1:0]           waddr_i,
  input  bst_pkg::lvl_entry_t     wdata_i,
  input  wire  [AW-1:0]           raddr_i,
  output bst_pkg::lvl_entry_t     rdata_o
);
  import bst_pkg::*;

  lvl_entry_t mem_q [DEPTH];
  lvl_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // forward a write that lands on the entry being fetched
    if (we_i && (waddr_i == raddr_i)) begin
      rdata_q <= wdata_i;
    end else begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ----- design/bst_out_buf.sv -----
`default_nettype none
module bst_out_buf (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          push_i,
  input  bst_pkg::tok_t tok_i,
  output logic         room_o,
  bst_tok_if.source    token_o
);
  import bst_pkg::*;

  tok_t head_q, head_d, skid_q, skid_d;
  logic head_v_q, head_v_d, skid_v_q, skid_v_d;
  logic pop;

  assign pop    = head_v_q && token_o.ready;
  assign room_o = !skid_v_q;

  always_comb begin
    head_d   = head_q;
    skid_d   = skid_q;
    head_v_d = head_v_q;
    skid_v_d = skid_v_q;
    if (pop) begin
      if (skid_v_q) begin
        head_d   = skid_q;
        skid_v_d = 1'b0;
      end else begin
        head_v_d = 1'b0;
      end
    end
    if (push_i) begin
      if (head_v_q && !pop) begin
        skid_d   = tok_i;
        skid_v_d = 1'b1;
      end else begin
        head_d   = tok_i;
        head_v_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      head_v_q <= head_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    skid_q <= skid_d;
  end

  assign token_o.valid          = head_v_q;
  assign token_o.token_kind     = head_q.kind;
  assign token_o.token_value    = head_q.value;
  assign token_o.byte_offset    = head_q.byte_offset;
  assign token_o.nest_level     = head_q.nest_level;
  assign token_o.is_dict_key    = head_q.is_dict_key;
  assign token_o.value_complete = head_q.value_complete;
  assign token_o.top_done       = head_q.top_done;

endmodule
`default_nettype wire

// ----- tb/sv/tb_top.sv -----
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import bst_pkg::*;

  localparam int unsigned NEST_CAP      = 32;
  localparam int unsigned LEN_W         = 32;
  localparam int          PHASES        = 6;
  localparam int          PHASE_BYTES   = 235;
  localparam int          SETTLE_CYCLES = 8;
  localparam int          REPORT_LIMIT  = 10;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } byte_item_t;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_PERIODIC,
    RX_TRICKLE
  } rx_style_e;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [5:0] cfg_wdata_i;

  bst_byte_if byte_if ();
  bst_tok_if  tok_if ();

  bencode_stream_tokenizer dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .byte_i     (byte_if),
    .token_o    (tok_if)
  );

  always #4 clk_i = ~clk_i;

  // Tokenizer state as the block should hold it
  mode_e       p_mode;
  logic [63:0] p_remaining;
  logic [63:0] p_mag;
  logic        p_neg;
  int unsigned p_lvl;
  logic        p_is_dict [NEST_CAP];
  logic        p_wants_key [NEST_CAP];
  logic [31:0] p_pos;
  logic [5:0]  p_max_depth;

  tok_t        expected_tokens [$];
  byte_item_t  byte_backlog [$];
  logic [7:0]  buf_bytes [$];
  int          mismatches = 0;

  // Stacks used while building a nested value
  bit          gen_is_dict [$];
  int          gen_left [$];
  bit          gen_need_key [$];

  string int_edge_text [11] = '{"9223372036854775807", "-9223372036854775808",
                                "9223372036854775808", "-9223372036854775809",
                                "99999999999999999999", "03", "-0", "-", "", "-07", "00"};
  string len_edge_text [7] = '{"4294967295:ab", "4294967296:", "99999999999:", "00:",
                               "0:", "01:a", "4294967295:"};
  string chaos_chars = "ilde:-0123456789";

  function automatic void clear_parse();
    int i;
    p_mode      = MODE_VALUE;
    p_remaining = '0;
    p_mag       = '0;
    p_neg       = 1'b0;
    p_lvl       = 0;
    for (i = 0; i < NEST_CAP; i++) begin
      p_is_dict[i]   = 1'b0;
      p_wants_key[i] = 1'b0;
    end
    p_pos = '0;
  endfunction

  function automatic bit in_key();
    if (p_lvl == 0) return 1'b0;
    return p_is_dict[p_lvl-1] && p_wants_key[p_lvl-1];
  endfunction

  function automatic void finish_value();
    if (p_lvl == 0) begin
      p_mode = MODE_DONE;
    end else begin
      p_mode = MODE_VALUE;
      if (p_is_dict[p_lvl-1]) p_wants_key[p_lvl-1] = !p_wants_key[p_lvl-1];
    end
  endfunction

  function automatic tok_t mk_token(kind_e k, logic [63:0] v, logic [31:0] off,
                                    int unsigned lvl, bit key, bit complete, bit top);
    tok_t t;
    t.kind           = k;
    t.value          = v;
    t.byte_offset    = off;
    t.nest_level     = 6'(lvl);
    t.is_dict_key    = key;
    t.value_complete = complete;
    t.top_done       = top;
    return t;
  endfunction

  function automatic void tokenize_byte(logic [7:0] b, logic last);
    tok_t        t;
    bit          have, fail, digit, key, indict, fin, empty;
    err_e        code;
    logic [31:0] pos;
    logic [63:0] d, nv, top_mag, lenmax;
    int unsigned lvl, lim;
    pos    = p_pos;
    digit  = (b >= CH_ZERO) && (b <= CH_NINE);
    d      = digit ? 64'(b - CH_ZERO) : 64'd0;
    lvl    = p_lvl;
    key    = in_key();
    have   = 1'b0;
    fail   = 1'b0;
    code   = ERR_BAD_BYTE;
    lim    = (p_max_depth < NEST_CAP) ? p_max_depth : NEST_CAP;
    lenmax = (64'd1 << LEN_W) - 64'd1;
    case (p_mode)
      MODE_VALUE: begin
        indict = (lvl > 0) && p_is_dict[lvl-1];
        if (b == CH_E) begin
          if (lvl == 0 || (indict && !key)) begin
            fail = 1'b1;
          end else begin
            t = mk_token(KIND_CLOSE, 64'd0, pos, lvl, 1'b0, 1'b1, lvl == 1);
            have = 1'b1;
            p_lvl = lvl - 1;
            finish_value();
          end
        end else if (key && !digit) begin
          fail = 1'b1;
        end else if (digit) begin
          p_mag  = d;
          p_mode = MODE_STRLEN;
        end else if (b == CH_I) begin
          p_mag  = '0;
          p_neg  = 1'b0;
          p_mode = MODE_INT_START;
        end else if (b == CH_L || b == CH_D) begin
          if (lvl >= lim) begin
            fail = 1'b1;
            code = ERR_DEPTH;
          end else begin
            p_is_dict[lvl]   = (b == CH_D);
            p_wants_key[lvl] = (b == CH_D);
            p_lvl = lvl + 1;
            t = mk_token((b == CH_D) ? KIND_DICT_OPEN : KIND_LIST_OPEN, 64'd0, pos, lvl + 1,
                         1'b0, 1'b0, 1'b0);
            have = 1'b1;
          end
        end else begin
          fail = 1'b1;
        end
      end
      MODE_STRLEN: begin
        if (digit) begin
          nv = p_mag * 64'd10 + d;
          if (p_mag == 0) begin
            fail = 1'b1;
          end else if (nv > lenmax) begin
            fail = 1'b1;
            code = ERR_LEN_OVF;
          end else begin
            p_mag = nv;
          end
        end else if (b == CH_COLON) begin
          empty = (p_mag == 0);
          t = mk_token(KIND_STR_HDR, p_mag, pos, lvl, key, empty, empty && lvl == 0);
          have = 1'b1;
          if (empty) begin
            finish_value();
          end else begin
            p_remaining = p_mag;
            p_mode      = MODE_STRBODY;
          end
        end else begin
          fail = 1'b1;
        end
      end
      MODE_STRBODY: begin
        if (p_remaining > 0) p_remaining--;
        fin = (p_remaining == 0);
        t = mk_token(KIND_STR_BYTE, 64'(b), pos, lvl, key, fin, fin && lvl == 0);
        have = 1'b1;
        if (fin) finish_value();
      end
      MODE_INT_START: begin
        if (b == CH_MINUS) begin
          p_neg  = 1'b1;
          p_mode = MODE_INT_NEG;
        end else if (digit) begin
          p_mag  = d;
          p_mode = MODE_INT_DIGITS;
        end else begin
          fail = 1'b1;
        end
      end
      MODE_INT_NEG: begin
        if (digit && d != 0) begin
          p_mag  = d;
          p_mode = MODE_INT_DIGITS;
        end else begin
          fail = 1'b1;
        end
      end
      MODE_INT_DIGITS: begin
        if (digit) begin
          top_mag = p_neg ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
          if (p_mag == 0) begin
            fail = 1'b1;
          end else if (p_mag > (top_mag - d) / 64'd10) begin
            fail = 1'b1;
            code = ERR_INT_OVF;
          end else begin
            p_mag = p_mag * 64'd10 + d;
          end
        end else if (b == CH_E) begin
          t = mk_token(KIND_INT, p_neg ? (64'd0 - p_mag) : p_mag, pos, lvl, 1'b0, 1'b1,
                       lvl == 0);
          have = 1'b1;
          finish_value();
        end else begin
          fail = 1'b1;
        end
      end
      default: ;
    endcase
    if (fail) begin
      t = mk_token(KIND_ERROR, 64'(code), pos, p_lvl, 1'b0, 1'b0, 1'b0);
      have = 1'b1;
      p_mode = MODE_ERROR;
    end
    if (last) begin
      // an unfinished value at the last byte overrides this byte's token
      if (p_mode != MODE_DONE && p_mode != MODE_ERROR) begin
        t = mk_token(KIND_ERROR, 64'(ERR_TRUNCATED), pos, p_lvl, 1'b0, 1'b0, 1'b0);
        have = 1'b1;
      end
      clear_parse();
    end else begin
      p_pos = pos + 1;
    end
    if (have) expected_tokens.push_back(t);
  endfunction

  function automatic string tok_str(tok_t t);
    return $sformatf("kind=%0d value=%0d offset=%0d level=%0d key=%0b complete=%0b top=%0b",
                     t.kind, t.value, t.byte_offset, t.nest_level, t.is_dict_key,
                     t.value_complete, t.top_done);
  endfunction

  function automatic void flag_mismatch(string msg);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) $display("%0t ns: %s", $realtime, msg);
  endfunction

  // Buffer construction

  function automatic void push_text(string s);
    int i;
    for (i = 0; i < s.len(); i++) buf_bytes.push_back(s[i]);
  endfunction

  function automatic logic [7:0] chaos_byte();
    if ($urandom_range(0, 1)) return 8'($urandom_range(0, 255));
    return chaos_chars[$urandom_range(0, chaos_chars.len() - 1)];
  endfunction

  function automatic void emit_string();
    int len, i;
    case ($urandom_range(0, 19))
      0: len = $urandom_range(13, 40);
      1, 2, 3, 4, 5: len = $urandom_range(5, 12);
      default: len = $urandom_range(0, 4);
    endcase
    push_text($sformatf("%0d:", len));
    for (i = 0; i < len; i++) buf_bytes.push_back(8'($urandom_range(0, 255)));
  endfunction

  function automatic void emit_int();
    longint v;
    case ($urandom_range(0, 9))
      0: v = 0;
      1: v = 64'h7fff_ffff_ffff_ffff;
      2: v = 64'h8000_0000_0000_0000;
      3, 4: v = {$urandom, $urandom};
      default: v = longint'($urandom_range(0, 2000)) - 1000;
    endcase
    push_text($sformatf("i%0de", v));
  endfunction

  function automatic void emit_value(int max_lvl, int open_pct);
    bit dict;
    if (gen_left.size() < max_lvl && $urandom_range(0, 99) < open_pct) begin
      dict = $urandom_range(0, 1);
      buf_bytes.push_back(dict ? CH_D : CH_L);
      gen_is_dict.push_back(dict);
      gen_left.push_back($urandom_range(0, 3));
      gen_need_key.push_back(dict);
    end else if ($urandom_range(0, 1)) begin
      emit_int();
    end else begin
      emit_string();
    end
  endfunction

  function automatic void gen_nested(int max_lvl);
    int top;
    gen_is_dict.delete();
    gen_left.delete();
    gen_need_key.delete();
    emit_value(max_lvl, 70);
    while (gen_left.size() != 0) begin
      top = gen_left.size() - 1;
      if (gen_is_dict[top] && gen_need_key[top] && gen_left[top] > 0) begin
        emit_string();
        gen_need_key[top] = 1'b0;
      end else if (gen_left[top] == 0) begin
        buf_bytes.push_back(CH_E);
        gen_is_dict.delete(top);
        gen_left.delete(top);
        gen_need_key.delete(top);
      end else begin
        gen_left[top]--;
        if (gen_is_dict[top]) gen_need_key[top] = 1'b1;
        emit_value(max_lvl, 35);
      end
    end
  endfunction

  function automatic void build_random_buffer();
    int sel, k, i;
    bit was_dict, wrap;
    buf_bytes.delete();
    sel = $urandom_range(0, 99);
    if (sel < 75) begin
      gen_nested($urandom_range(1, 5));
      if (sel < 55) begin
        // trailing bytes after the top value
        if ($urandom_range(0, 4) == 0) begin
          k = $urandom_range(1, 4);
          for (i = 0; i < k; i++) buf_bytes.push_back(chaos_byte());
        end
      end else if (sel < 65) begin
        if (buf_bytes.size() > 1) begin
          k = $urandom_range(1, buf_bytes.size() - 1);
          buf_bytes = buf_bytes[0:k-1];
        end
      end else begin
        k = $urandom_range(0, buf_bytes.size() - 1);
        if ($urandom_range(0, 1)) buf_bytes[k] = chaos_byte();
        else buf_bytes.insert(k, chaos_byte());
      end
    end else if (sel < 80) begin
      k = $urandom_range(1, NEST_CAP + 2);
      was_dict = 1'b0;
      for (i = 0; i < k; i++) begin
        was_dict = ($urandom_range(0, 3) == 0);
        if (was_dict) push_text("d1:k");
        else push_text("l");
      end
      if (was_dict) push_text("0:");
      if ($urandom_range(0, 1)) begin
        for (i = 0; i < k; i++) buf_bytes.push_back(CH_E);
      end
    end else if (sel < 87) begin
      wrap = $urandom_range(0, 1);
      if (wrap) push_text("l");
      push_text("i");
      push_text(int_edge_text[$urandom_range(0, 10)]);
      push_text("e");
      if (wrap) push_text("e");
    end else if (sel < 91) begin
      push_text(len_edge_text[$urandom_range(0, 6)]);
    end else begin
      k = $urandom_range(1, 6);
      for (i = 0; i < k; i++) buf_bytes.push_back(chaos_byte());
    end
  endfunction

  function automatic int commit_buffer();
    int i, n;
    byte_item_t it;
    n = buf_bytes.size();
    for (i = 0; i < n; i++) begin
      it.data = buf_bytes[i];
      it.last = (i == n - 1);
      byte_backlog.push_back(it);
    end
    buf_bytes.delete();
    return n;
  endfunction

  // Driver: bursts of transactions with random gaps

  int gap_left   = 0;
  int burst_left = 0;

  always @(posedge clk_i) begin
    byte_item_t nxt;
    if (!rst_ni) begin
      byte_if.valid <= 1'b0;
    end else begin
      if (byte_if.valid && byte_if.ready) begin
        tokenize_byte(byte_if.data_byte, byte_if.buffer_end);
      end
      if (!byte_if.valid || byte_if.ready) begin
        if (gap_left > 0 || byte_backlog.size() == 0) begin
          if (gap_left > 0) gap_left--;
          byte_if.valid <= 1'b0;
        end else begin
          nxt = byte_backlog.pop_front();
          byte_if.valid      <= 1'b1;
          byte_if.data_byte  <= nxt.data;
          byte_if.buffer_end <= nxt.last;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end
  end

  // Receiver: stall style changes every span of cycles

  rx_style_e rx_style  = RX_OPEN;
  int        rx_span   = 0;
  int        rx_period = 2;
  int        rx_tick   = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      tok_if.ready <= 1'b0;
    end else begin
      if (rx_span == 0) begin
        rx_style  = rx_style_e'($urandom_range(0, 3));
        rx_span   = $urandom_range(16, 200);
        rx_period = $urandom_range(2, 6);
      end else begin
        rx_span--;
      end
      rx_tick++;
      case (rx_style)
        RX_OPEN: begin
          tok_if.ready <= 1'b1;
        end
        RX_COIN: begin
          tok_if.ready <= 1'($urandom_range(0, 1));
        end
        RX_PERIODIC: begin
          tok_if.ready <= (rx_tick % rx_period) != 0;
        end
        default: begin
          tok_if.ready <= ($urandom_range(0, 5) == 0);
        end
      endcase
    end
  end

  // Monitor

  always @(posedge clk_i) begin
    tok_t got, want;
    if (rst_ni && tok_if.valid && tok_if.ready) begin
      got.kind           = kind_e'(tok_if.token_kind);
      got.value          = tok_if.token_value;
      got.byte_offset    = tok_if.byte_offset;
      got.nest_level     = tok_if.nest_level;
      got.is_dict_key    = tok_if.is_dict_key;
      got.value_complete = tok_if.value_complete;
      got.top_done       = tok_if.top_done;
      if (expected_tokens.size() == 0) begin
        flag_mismatch({"unexpected token: ", tok_str(got)});
      end else begin
        want = expected_tokens.pop_front();
        if (got !== want) begin
          flag_mismatch({"token mismatch: expected ", tok_str(want), " got ", tok_str(got)});
        end
      end
    end
  end

  task automatic wait_idle();
    while (byte_backlog.size() != 0 || byte_if.valid || expected_tokens.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_depth(logic [5:0] v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    p_max_depth = v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    int ph, sent;
    logic [5:0] depth;
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_wdata_i        = '0;
    byte_if.valid      = 1'b0;
    byte_if.data_byte  = '0;
    byte_if.buffer_end = 1'b0;
    tok_if.ready       = 1'b0;
    p_max_depth        = 6'd32;
    clear_parse();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      case (ph)
        0, 4: depth = 6'd32;
        1: depth = 6'd1;
        2: depth = 6'd2;
        3: depth = 6'($urandom_range(3, 31));
        default: depth = 6'($urandom_range(1, 32));
      endcase
      write_depth(depth);
      sent = 0;
      if (ph == 0) begin
        push_text("le");
        sent += commit_buffer();
        push_text("d1:");
        buf_bytes.push_back(8'hff);
        push_text("i-1ee");
        sent += commit_buffer();
        // leading zero, stray close, negative zero, cut-off string
        push_text("i03e");
        sent += commit_buffer();
        push_text("e");
        sent += commit_buffer();
        push_text("i-0e");
        sent += commit_buffer();
        push_text("3:a");
        sent += commit_buffer();
      end
      while (sent < PHASE_BYTES) begin
        build_random_buffer();
        sent += commit_buffer();
      end
    end

    wait_idle();
    if (mismatches == 0 && expected_tokens.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
